// ===== rtl/core/sqalu_pkg.sv =====
// Shared constants for the saturating Q10.5 fixed-point ALU.
// Operation codes, infinity codes and parameter defaults; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sqalu_pkg;
    localparam int MODE_W = 5;
    localparam int WORD_W = 16;
    localparam int DEF_FRACTION_BITS = 5;
    localparam int DEF_ROOT_ITERATIONS = 20;

    localparam logic signed [WORD_W-1:0] POS_INF = 16'sh7FFF;
    localparam logic signed [WORD_W-1:0] NEG_INF = 16'sh8000;

    localparam logic [MODE_W-1:0] OP_ADD   = 5'd0;
    localparam logic [MODE_W-1:0] OP_SUB   = 5'd1;
    localparam logic [MODE_W-1:0] OP_MUL   = 5'd2;
    localparam logic [MODE_W-1:0] OP_DIV   = 5'd3;
    localparam logic [MODE_W-1:0] OP_MOD   = 5'd4;
    localparam logic [MODE_W-1:0] OP_NEG   = 5'd5;
    localparam logic [MODE_W-1:0] OP_EQ    = 5'd6;
    localparam logic [MODE_W-1:0] OP_NE    = 5'd7;
    localparam logic [MODE_W-1:0] OP_GE    = 5'd8;
    localparam logic [MODE_W-1:0] OP_LE    = 5'd9;
    localparam logic [MODE_W-1:0] OP_GT    = 5'd10;
    localparam logic [MODE_W-1:0] OP_LT    = 5'd11;
    localparam logic [MODE_W-1:0] OP_SGN   = 5'd12;
    localparam logic [MODE_W-1:0] OP_ROUND = 5'd13;
    localparam logic [MODE_W-1:0] OP_TRUNC = 5'd14;
    localparam logic [MODE_W-1:0] OP_FRAC  = 5'd15;
    localparam logic [MODE_W-1:0] OP_SQRT  = 5'd16;
    localparam logic [MODE_W-1:0] OP_CBRT  = 5'd17;
endpackage
`default_nettype wire

// ===== rtl/core/sqalu_div.sv =====
// Bit-serial restoring divider on unsigned magnitudes, one quotient bit per cycle.
// Standalone; instantiated by the ALU top level.
`timescale 1ns / 1ps
`default_nettype none
module sqalu_div #(
    parameter int NW = 21,
    parameter int DW = 21
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quo,
    output logic [DW-1:0]      rem
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] quo_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        if (!diff[DW])
        begin
            rem_next = diff[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

// ===== rtl/core/saturating_q10_5_fixed_point_alu_unit.sv =====
// Saturating Q10.5 fixed-point ALU: one beat in, one beat out, one item at a time.
// Uses sqalu_pkg and the bit-serial divider sqalu_div.
// Simple modes do not use the divider; divide and modulo run one pass of the
// serial divider. Square root runs two divides per Newton step and cube root
// three, for at most ROOT_ITERATIONS steps.
// A finished result waits in the output register; the next beat is taken once the
// result has moved into that register.
`timescale 1ns / 1ps
`default_nettype none
module saturating_q10_5_fixed_point_alu_unit #(
    parameter int FRACTION_BITS   = sqalu_pkg::DEF_FRACTION_BITS,
    parameter int ROOT_ITERATIONS = sqalu_pkg::DEF_ROOT_ITERATIONS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sqalu_pkg::MODE_W-1:0] mode,
    input  wire logic signed [15:0]          operand_a,
    input  wire logic signed [15:0]          operand_b,
    input  wire logic                        b_is_integer,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [15:0]               result,
    output logic                             flag
);
    localparam int F  = FRACTION_BITS;
    localparam int BW = 16 + F;
    localparam int NW = 16 + F;
    localparam int SW = 16 + BW + 1;
    localparam int IW = $clog2(ROOT_ITERATIONS + 1);
    localparam logic signed [BW-1:0] ONE_W   = BW'(1) <<< F;
    localparam logic signed [BW-1:0] TWO_W   = BW'(2) <<< F;
    localparam logic signed [BW-1:0] THREE_W = BW'(3) <<< F;
    localparam logic signed [15:0]   ONE_16  = 16'(1) <<< F;
    localparam logic signed [16:0]   HALF_17 = 17'(1) <<< (F - 1);
    localparam logic signed [16:0]   MASK_17 = (17'(1) <<< F) - 17'sd1;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_DIVGO, S_DIVRUN, S_NEXT, S_DONE
    } state_t;

    function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] v);
        if (v > SW'(sqalu_pkg::POS_INF))
            return sqalu_pkg::POS_INF;
        else if (v < SW'(sqalu_pkg::NEG_INF))
            return sqalu_pkg::NEG_INF;
        else
            return v[15:0];
    endfunction

    function automatic logic is_inf(input logic signed [15:0] x);
        return (x == sqalu_pkg::POS_INF) || (x == sqalu_pkg::NEG_INF);
    endfunction

    function automatic logic signed [15:0] sinf(input logic signed [15:0] x);
        return x[15] ? sqalu_pkg::NEG_INF : sqalu_pkg::POS_INF;
    endfunction

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] x,
                                                   input logic signed [BW-1:0] y);
        logic signed [SW-1:0] s;
        s = SW'(x) + SW'(y);
        if (is_inf(x))
            return x;
        else
            return sat16(s);
    endfunction

    function automatic logic signed [15:0] tdiv_pow2(input logic signed [16:0] x);
        logic signed [16:0] t;
        t = x[16] ? (x + MASK_17) : x;
        return 16'(t >>> F);
    endfunction

    state_t state_reg;
    logic [sqalu_pkg::MODE_W-1:0] op_reg;
    logic signed [15:0]   a_reg;
    logic signed [BW-1:0] bw_reg;
    logic signed [15:0]   dx_reg;
    logic signed [BW-1:0] dy_reg;
    logic                 dmod_reg;
    logic                 dneg_reg;
    logic                 dasign_reg;
    logic signed [15:0]   dres_reg;
    logic signed [15:0]   r0_reg;
    logic [1:0]           step_reg;
    logic [IW-1:0]        iter_reg;
    logic signed [15:0]   res_reg;
    logic                 flag_reg;
    logic                 out_valid_reg;
    logic signed [15:0]   out_res_reg;
    logic                 out_flag_reg;

    logic signed [BW-1:0]     b_full;
    logic signed [16+BW-1:0]  prod;
    logic signed [SW-1:0]     prod_sh;
    logic signed [BW:0]       a_ext;
    logic signed [BW:0]       b_ext;
    logic signed [15:0]       exec_res;
    logic                     exec_flag;

    logic                 spec;
    logic signed [15:0]   spec_res;
    logic [15:0]          xmag;
    logic [BW-1:0]        ymag;
    logic [NW-1:0]        div_num;
    logic                 div_start;
    logic                 div_done;
    logic [NW-1:0]        div_quo;
    logic [BW-1:0]        div_rem;
    logic signed [15:0]   fin_res;

    assign b_full = b_is_integer ? (BW'(operand_b) <<< F) : BW'(operand_b);

    always_comb
    begin
        prod    = (16+BW)'(a_reg) * (16+BW)'(bw_reg);
        prod_sh = SW'(prod >>> F);
        a_ext   = (BW+1)'(a_reg);
        b_ext   = (BW+1)'(bw_reg);
        exec_res  = '0;
        exec_flag = 1'b0;
        case (op_reg)
            sqalu_pkg::OP_ADD: exec_res = sat_add(a_reg, bw_reg);
            sqalu_pkg::OP_SUB: exec_res = is_inf(a_reg) ? a_reg
                                        : sat16(SW'(a_reg) - SW'(bw_reg));
            sqalu_pkg::OP_MUL: exec_res = is_inf(a_reg) ? a_reg : sat16(prod_sh);
            sqalu_pkg::OP_NEG:
            begin
                if (a_reg == sqalu_pkg::POS_INF)
                    exec_res = sqalu_pkg::NEG_INF;
                else if (a_reg == sqalu_pkg::NEG_INF)
                    exec_res = sqalu_pkg::POS_INF;
                else
                    exec_res = -a_reg;
            end
            sqalu_pkg::OP_EQ: exec_flag = (a_ext == b_ext);
            sqalu_pkg::OP_NE: exec_flag = (a_ext != b_ext);
            sqalu_pkg::OP_GE: exec_flag = (a_ext >= b_ext);
            sqalu_pkg::OP_LE: exec_flag = (a_ext <= b_ext);
            sqalu_pkg::OP_GT: exec_flag = (a_ext > b_ext);
            sqalu_pkg::OP_LT: exec_flag = (a_ext < b_ext);
            sqalu_pkg::OP_SGN:
                exec_res = (a_reg == 16'sd0) ? 16'sd0 : (a_reg[15] ? -16'sd1 : 16'sd1);
            sqalu_pkg::OP_ROUND: exec_res = tdiv_pow2(17'(a_reg) + HALF_17);
            sqalu_pkg::OP_TRUNC: exec_res = tdiv_pow2(17'(a_reg));
            sqalu_pkg::OP_FRAC:  exec_res = a_reg & (ONE_16 - 16'sd1);
            default: exec_res = '0;
        endcase
    end

    // divide launch: special cases resolve without the serial divider
    always_comb
    begin
        spec     = 1'b0;
        spec_res = '0;
        if (is_inf(dx_reg))
        begin
            spec     = 1'b1;
            spec_res = dx_reg;
        end
        else if ((dy_reg == '0) || (dmod_reg && ((dy_reg >= BW'(sqalu_pkg::POS_INF))
                 || (dy_reg <= BW'(sqalu_pkg::NEG_INF)))))
        begin
            spec     = 1'b1;
            spec_res = sinf(dx_reg);
        end
        xmag    = dx_reg[15] ? 16'(-dx_reg) : 16'(dx_reg);
        ymag    = dy_reg[BW-1] ? BW'(-dy_reg) : BW'(dy_reg);
        div_num = dmod_reg ? NW'(xmag) : (NW'(xmag) << F);
        div_start = (state_reg == S_DIVGO) && !spec;
    end

    always_comb
    begin
        if (dmod_reg)
            fin_res = dasign_reg ? -16'(div_rem) : 16'(div_rem);
        else if (dneg_reg)
            fin_res = (div_quo > NW'(32768)) ? sqalu_pkg::NEG_INF : -16'(div_quo);
        else
            fin_res = (div_quo > NW'(32767)) ? sqalu_pkg::POS_INF : 16'(div_quo);
    end

    sqalu_div #(
        .NW(NW),
        .DW(BW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (ymag),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            iter_reg      <= '0;
            op_reg        <= sqalu_pkg::OP_ADD;
            a_reg         <= '0;
            bw_reg        <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            dmod_reg      <= 1'b0;
            dneg_reg      <= 1'b0;
            dasign_reg    <= 1'b0;
            dres_reg      <= '0;
            r0_reg        <= '0;
            res_reg       <= '0;
            flag_reg      <= 1'b0;
            out_res_reg   <= '0;
            out_flag_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_DONE) && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= mode;
                        a_reg     <= operand_a;
                        bw_reg    <= b_full;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_reg  <= exec_res;
                    flag_reg <= exec_flag;
                    step_reg <= '0;
                    iter_reg <= '0;
                    r0_reg   <= ONE_16;
                    dx_reg   <= a_reg;
                    dmod_reg <= (op_reg == sqalu_pkg::OP_MOD);
                    if ((op_reg == sqalu_pkg::OP_DIV) || (op_reg == sqalu_pkg::OP_MOD))
                    begin
                        dy_reg    <= bw_reg;
                        state_reg <= S_DIVGO;
                    end
                    else if ((op_reg == sqalu_pkg::OP_SQRT)
                             || (op_reg == sqalu_pkg::OP_CBRT))
                    begin
                        dy_reg    <= ONE_W;
                        state_reg <= S_DIVGO;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_DIVGO:
                begin
                    dneg_reg   <= dx_reg[15] ^ dy_reg[BW-1];
                    dasign_reg <= dx_reg[15];
                    if (spec)
                    begin
                        dres_reg  <= spec_res;
                        state_reg <= S_NEXT;
                    end
                    else
                        state_reg <= S_DIVRUN;
                end
                S_DIVRUN:
                begin
                    if (div_done)
                    begin
                        dres_reg  <= fin_res;
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if ((op_reg != sqalu_pkg::OP_SQRT) && (op_reg != sqalu_pkg::OP_CBRT))
                    begin
                        res_reg   <= dres_reg;
                        state_reg <= S_DONE;
                    end
                    else if ((op_reg == sqalu_pkg::OP_SQRT) && (step_reg == 2'd0))
                    begin
                        dx_reg    <= sat_add(dres_reg, BW'(r0_reg));
                        dy_reg    <= TWO_W;
                        step_reg  <= 2'd1;
                        state_reg <= S_DIVGO;
                    end
                    else if ((op_reg == sqalu_pkg::OP_CBRT) && (step_reg == 2'd0))
                    begin
                        dx_reg    <= dres_reg;
                        dy_reg    <= BW'(r0_reg);
                        step_reg  <= 2'd1;
                        state_reg <= S_DIVGO;
                    end
                    else if ((op_reg == sqalu_pkg::OP_CBRT) && (step_reg == 2'd1))
                    begin
                        dx_reg    <= sat_add(sat_add(dres_reg, BW'(r0_reg)), BW'(r0_reg));
                        dy_reg    <= THREE_W;
                        step_reg  <= 2'd2;
                        state_reg <= S_DIVGO;
                    end
                    else if ((dres_reg == r0_reg) || (iter_reg == IW'(ROOT_ITERATIONS - 1)))
                    begin
                        res_reg   <= dres_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        r0_reg    <= dres_reg;
                        iter_reg  <= iter_reg + 1'b1;
                        dx_reg    <= a_reg;
                        dy_reg    <= BW'(dres_reg);
                        step_reg  <= 2'd0;
                        state_reg <= S_DIVGO;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_res_reg  <= res_reg;
                        out_flag_reg <= flag_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = out_res_reg;
    assign flag      = out_flag_reg;
endmodule
`default_nettype wire

// ===== rtl/core/sqalu_chk.sv =====
// Port-level checker for the saturating Q10.5 ALU, bound to the top level.
// Uses only the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module sqalu_chk (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [15:0] result,
    input wire logic               flag
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result) && $stable(flag))
        else $error("output beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken while busy");

    a_flag_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flag |-> result == 16'sd0)
        else $error("compare beat carries a nonzero result");

    a_no_out_right_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared without work cycles");
endmodule

bind saturating_q10_5_fixed_point_alu_unit sqalu_chk u_sqalu_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .flag      (flag)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for saturating_q10_5_fixed_point_alu_unit.
// Directed table then random beats, checked against a built-in predictor.
// Depends on sqalu_pkg and the ALU RTL.
`timescale 1ns / 1ps
module tb;
    localparam int FB = sqalu_pkg::DEF_FRACTION_BITS;
    localparam int ROOT_STEPS = sqalu_pkg::DEF_ROOT_ITERATIONS;
    localparam longint ONE = longint'(1) << FB;
    localparam int N_RANDOM = 1830;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [sqalu_pkg::MODE_W-1:0] op;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic bint;
        logic has_res;
        logic signed [15:0] res;
    } stim_row_t;

    typedef struct {
        logic signed [15:0] res;
        logic flg;
    } alu_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [sqalu_pkg::MODE_W-1:0] mode;
    logic signed [15:0] operand_a;
    logic signed [15:0] operand_b;
    logic b_is_integer;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] result;
    logic flag;

    alu_result_t expected_q[$];
    int errors;
    longint cycles = 0;
    int stall_left = 0;
    bit quiet;
    stim_row_t rows[$];

    saturating_q10_5_fixed_point_alu_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .operand_a(operand_a), .operand_b(operand_b),
        .b_is_integer(b_is_integer),
        .out_valid(out_valid), .out_ready(out_ready),
        .result(result), .flag(flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sat(longint v);
        if (v > sqalu_pkg::POS_INF) return sqalu_pkg::POS_INF;
        if (v < sqalu_pkg::NEG_INF) return sqalu_pkg::NEG_INF;
        return v;
    endfunction

    function automatic bit infinite(longint a);
        return a == sqalu_pkg::POS_INF || a == sqalu_pkg::NEG_INF;
    endfunction

    function automatic longint inf_of(longint a);
        return a >= 0 ? sqalu_pkg::POS_INF : sqalu_pkg::NEG_INF;
    endfunction

    function automatic longint q_add(longint a, longint b);
        if (infinite(a)) return a;
        return sat(a + b);
    endfunction

    function automatic longint q_div(longint a, longint b);
        if (infinite(a)) return a;
        if (b == 0) return inf_of(a);
        return sat((a * ONE) / b);
    endfunction

    function automatic longint q_mul(longint a, longint b);
        longint p;
        if (infinite(a)) return a;
        p = a * b;
        if (p >= 0) return sat(p / ONE);
        return sat(-((-p + ONE - 1) / ONE));
    endfunction

    function automatic longint q_root(longint a, bit cube);
        longint r0;
        longint r;
        longint t;
        r0 = ONE;
        r = 0;
        for (int i = 0; i < ROOT_STEPS; i++)
        begin
            if (cube)
            begin
                t = q_div(q_div(a, r0), r0);
                r = q_div(q_add(q_add(t, r0), r0), 3 * ONE);
            end
            else
                r = q_div(q_add(q_div(a, r0), r0), 2 * ONE);
            if (r == r0) break;
            r0 = r;
        end
        return r;
    endfunction

    function automatic alu_result_t predict_alu(logic [sqalu_pkg::MODE_W-1:0] op,
                                                logic signed [15:0] ai,
                                                logic signed [15:0] bi, logic bint);
        alu_result_t o;
        longint a;
        longint bw;
        longint r;
        a = ai;
        bw = bint ? longint'(bi) * ONE : longint'(bi);
        r = 0;
        o.flg = 1'b0;
        case (op)
            sqalu_pkg::OP_ADD:   r = q_add(a, bw);
            sqalu_pkg::OP_SUB:   r = infinite(a) ? a : sat(a - bw);
            sqalu_pkg::OP_MUL:   r = q_mul(a, bw);
            sqalu_pkg::OP_DIV:   r = q_div(a, bw);
            sqalu_pkg::OP_MOD:
                if (infinite(a)) r = a;
                else if (bw == 0 || bw >= sqalu_pkg::POS_INF || bw <= sqalu_pkg::NEG_INF)
                    r = inf_of(a);
                else r = a % bw;
            sqalu_pkg::OP_NEG:
                r = a == sqalu_pkg::POS_INF ? sqalu_pkg::NEG_INF
                  : (a == sqalu_pkg::NEG_INF ? sqalu_pkg::POS_INF : -a);
            sqalu_pkg::OP_EQ:    o.flg = a == bw;
            sqalu_pkg::OP_NE:    o.flg = a != bw;
            sqalu_pkg::OP_GE:    o.flg = a >= bw;
            sqalu_pkg::OP_LE:    o.flg = a <= bw;
            sqalu_pkg::OP_GT:    o.flg = a > bw;
            sqalu_pkg::OP_LT:    o.flg = a < bw;
            sqalu_pkg::OP_SGN:   r = a > 0 ? 1 : (a == 0 ? 0 : -1);
            sqalu_pkg::OP_ROUND: r = (a + ONE / 2) / ONE;
            sqalu_pkg::OP_TRUNC: r = a / ONE;
            sqalu_pkg::OP_FRAC:  r = a & (ONE - 1);
            sqalu_pkg::OP_SQRT:  r = q_root(a, 1'b0);
            sqalu_pkg::OP_CBRT:  r = q_root(a, 1'b1);
            default:  r = 0;
        endcase
        o.res = r[15:0];
        return o;
    endfunction

    function automatic stim_row_t mk(logic [sqalu_pkg::MODE_W-1:0] op, int a, int b,
                                     bit bint, bit has, int res);
        stim_row_t s;
        s.op = op;
        s.a = a[15:0];
        s.b = b[15:0];
        s.bint = bint;
        s.has_res = has;
        s.res = res[15:0];
        return s;
    endfunction

    function automatic logic signed [15:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? sqalu_pkg::POS_INF : sqalu_pkg::NEG_INF;
            1: return 16'($signed($urandom_range(0, 128)) - 64);
            2: return 16'($signed($urandom_range(0, 8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_beat(logic [sqalu_pkg::MODE_W-1:0] op, logic signed [15:0] a,
                             logic signed [15:0] b, logic bint);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= op;
        operand_a <= a;
        operand_b <= b;
        b_is_integer <= bint;
        expected_q.push_back(predict_alu(op, a, b, bint));
        do @(posedge clk); while (!in_ready);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                stall_left <= $urandom_range(0, 9);
            end
            else
                out_ready <= 1'b1;
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %0d flag %0d", $time, result, flag);
                end
                else
                begin
                    if (result !== expected_q[0].res)
                    begin
                        errors++;
                        $display("%0t: result expected %0d actual %0d", $time,
                                 expected_q[0].res, result);
                    end
                    if (flag !== expected_q[0].flg)
                    begin
                        errors++;
                        $display("%0t: flag expected %0d actual %0d", $time,
                                 expected_q[0].flg, flag);
                    end
                    void'(expected_q.pop_front());
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        mode = sqalu_pkg::OP_ADD;
        operand_a = '0;
        operand_b = '0;
        b_is_integer = 1'b0;
        errors = 0;
        quiet = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        rows.push_back(mk(sqalu_pkg::OP_ADD, 32767, -100, 0, 1, 32767));
        rows.push_back(mk(sqalu_pkg::OP_ADD, 32000, 32000, 0, 1, 32767));
        rows.push_back(mk(sqalu_pkg::OP_SUB, -32000, 32000, 0, 1, -32768));
        rows.push_back(mk(sqalu_pkg::OP_SUB, -32768, 5, 0, 1, -32768));
        rows.push_back(mk(sqalu_pkg::OP_ADD, 10, 32767, 1, 1, 32767));
        rows.push_back(mk(sqalu_pkg::OP_MUL, 64, 96, 0, 1, 192));
        rows.push_back(mk(sqalu_pkg::OP_MUL, -1, 1, 0, 1, -1));
        rows.push_back(mk(sqalu_pkg::OP_MUL, 20000, 20000, 0, 1, 32767));
        rows.push_back(mk(sqalu_pkg::OP_DIV, 64, 0, 0, 1, 32767));
        rows.push_back(mk(sqalu_pkg::OP_DIV, -64, 0, 1, 1, -32768));
        rows.push_back(mk(sqalu_pkg::OP_DIV, 96, 2, 1, 0, 0));
        rows.push_back(mk(sqalu_pkg::OP_MOD, 100, 32767, 0, 1, 32767));
        rows.push_back(mk(sqalu_pkg::OP_MOD, -100, 0, 0, 1, -32768));
        rows.push_back(mk(sqalu_pkg::OP_MOD, -100, 7, 0, 1, -2));
        rows.push_back(mk(sqalu_pkg::OP_NEG, 32767, 0, 0, 1, -32768));
        rows.push_back(mk(sqalu_pkg::OP_NEG, -32768, 0, 0, 1, 32767));
        rows.push_back(mk(sqalu_pkg::OP_EQ, 64, 2, 1, 0, 0));
        rows.push_back(mk(sqalu_pkg::OP_NE, 3, 3, 0, 0, 0));
        rows.push_back(mk(sqalu_pkg::OP_GE, 32767, 32767, 1, 0, 0));
        rows.push_back(mk(sqalu_pkg::OP_LE, -32768, -32768, 1, 0, 0));
        rows.push_back(mk(sqalu_pkg::OP_GT, 5, -3, 0, 0, 0));
        rows.push_back(mk(sqalu_pkg::OP_LT, -1, 0, 0, 0, 0));
        rows.push_back(mk(sqalu_pkg::OP_SGN, -5, 0, 0, 1, -1));
        rows.push_back(mk(sqalu_pkg::OP_ROUND, 48, 0, 0, 1, 2));
        rows.push_back(mk(sqalu_pkg::OP_TRUNC, -48, 0, 0, 1, -1));
        rows.push_back(mk(sqalu_pkg::OP_FRAC, -1, 0, 0, 1, 31));
        rows.push_back(mk(sqalu_pkg::OP_SQRT, 128, 0, 0, 0, 0));
        rows.push_back(mk(sqalu_pkg::OP_SQRT, -32768, 0, 0, 0, 0));
        rows.push_back(mk(sqalu_pkg::OP_CBRT, 256, 0, 0, 0, 0));
        rows.push_back(mk(sqalu_pkg::OP_CBRT, 32767, 0, 0, 0, 0));
        rows.push_back(mk(5'd31, 1234, 0, 1, 1, 0));

        foreach (rows[i])
        begin
            if (rows[i].has_res && predict_alu(rows[i].op, rows[i].a, rows[i].b,
                                               rows[i].bint).res !== rows[i].res)
            begin
                errors++;
                $display("%0t: table row %0d expected %0d actual %0d", $time, i,
                         rows[i].res, predict_alu(rows[i].op, rows[i].a, rows[i].b,
                                                  rows[i].bint).res);
            end
            send_beat(rows[i].op, rows[i].a, rows[i].b, rows[i].bint);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n > N_RANDOM - 150) quiet = 1;
            send_beat($urandom_range(0, 9) == 0 ? 5'($urandom) : 5'($urandom_range(0, 17)),
                      rand_word(), rand_word(), 1'($urandom));
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("** saturating_q10_5_fixed_point_alu_unit: PASSED **");
        else
            $display("** saturating_q10_5_fixed_point_alu_unit: FAILED **");
        $finish;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("** saturating_q10_5_fixed_point_alu_unit: FAILED **");
        $finish;
    end
endmodule
